@@ sv/seven_segment_decimal_scan_driver_top_assert.svh @@
// assertion macros for the seven-segment scan driver
`ifndef SEVEN_SEGMENT_DECIMAL_SCAN_DRIVER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_DECIMAL_SCAN_DRIVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SSD_ASSERT_IMPL(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SSD_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define SSD_ASSERT_IMPL(lbl, prop, msg)
`define SSD_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

@@ sv/ssd_pkg.sv @@
// shared types, constants and functions for the seven-segment scan driver
package ssd_pkg;

	localparam int VALUE_W         = 27;
	localparam int DIGIT_SEL_W     = 3;
	localparam int SEG_W           = 7;
	localparam int BCD_DIGITS      = 9;
	localparam int STEP_CNT_W      = 5;
	localparam int IN_TDATA_W      = 32;
	localparam int OUT_TDATA_W     = 16;
	localparam int DIGIT_COUNT_DEF = 8;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_SCAN = 1'b1;

	typedef struct packed {
		logic load;
		logic shift;
		logic write;
		logic scan;
	} ssd_cmd_t;

	typedef struct packed {
		logic conv_done;
		logic out_stall;
	} ssd_status_t;

	function automatic logic [SEG_W-1:0] seg_encode(input logic [3:0] digit);
		logic [SEG_W-1:0] seg;
		case (digit)
			4'd0: seg = 7'h3F;
			4'd1: seg = 7'h06;
			4'd2: seg = 7'h5B;
			4'd3: seg = 7'h4F;
			4'd4: seg = 7'h66;
			4'd5: seg = 7'h6D;
			4'd6: seg = 7'h7D;
			4'd7: seg = 7'h07;
			4'd8: seg = 7'h7F;
			4'd9: seg = 7'h6F;
			default: seg = '0;
		endcase
		return seg;
	endfunction

	// largest value shown on n digits, clamped to the input range
	function automatic logic [VALUE_W-1:0] max_shown(input int n);
		longint unsigned m;
		longint unsigned lim;
		m = 64'd1;
		lim = (64'd1 << VALUE_W) - 64'd1;
		for (int k = 0; k < n; k++) begin
			m = m * 64'd10;
		end
		m = m - 64'd1;
		if (m > lim) begin
			m = lim;
		end
		return m[VALUE_W-1:0];
	endfunction

endpackage

@@ sv/ssd_ctrl.sv @@
// controller state machine of the seven-segment scan driver
module ssd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_kind,
	output logic               in_ready,
	input  ssd_pkg::ssd_status_t status,
	output ssd_pkg::ssd_cmd_t    cmd
);
	import ssd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CONV  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		in_ready  = (state_q == ST_IDLE) && !status.out_stall;
		cmd       = '0;
		cmd.load  = in_valid && in_ready && (in_kind == KIND_LOAD);
		cmd.scan  = in_valid && in_ready && (in_kind == KIND_SCAN);
		cmd.shift = (state_q == ST_CONV);
		cmd.write = (state_q == ST_WRITE);
		state_d   = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (status.conv_done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/ssd_dp.sv @@
// datapath: binary to bcd shifter, digit buffer, scan position and output register
module ssd_dp #(
	parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ssd_pkg::ssd_cmd_t            cmd,
	output ssd_pkg::ssd_status_t         status,
	input  logic [ssd_pkg::VALUE_W-1:0]  in_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ssd_pkg::DIGIT_SEL_W-1:0] out_sel,
	output logic [ssd_pkg::SEG_W-1:0]    out_seg
);
	import ssd_pkg::*;

	localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int BCD_W = 4 * BCD_DIGITS;
	localparam logic [VALUE_W-1:0] SAT_LIMIT = max_shown(DIGIT_COUNT);

	logic [VALUE_W-1:0]    val_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [BCD_DIGITS-1:0] upper_nz;
	logic [SEG_W-1:0]      patt_q   [DIGIT_COUNT];
	logic [SEG_W-1:0]      new_patt [DIGIT_COUNT];
	logic [POS_W-1:0]      pos_q;
	logic [DIGIT_SEL_W-1:0] sel_q;
	logic [SEG_W-1:0]      seg_q;
	logic                  valid_q;

	// add 3 to every digit of five or more before the shift
	always_comb begin
		logic [3:0] d;
		for (int k = 0; k < BCD_DIGITS; k++) begin
			d = bcd_q[4*k +: 4];
			bcd_adj[4*k +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
		end
	end

	// digit k or a higher one is nonzero
	always_comb begin
		upper_nz[BCD_DIGITS-1] = (bcd_q[BCD_W-1 -: 4] != 4'd0);
		for (int k = BCD_DIGITS - 2; k >= 0; k--) begin
			upper_nz[k] = upper_nz[k+1] | (bcd_q[4*k +: 4] != 4'd0);
		end
	end

	for (genvar gi = 0; gi < DIGIT_COUNT; gi++) begin : g_patt
		localparam int R = DIGIT_COUNT - 1 - gi;
		if (R < BCD_DIGITS) begin : g_digit
			assign new_patt[gi] = (1'(R == 0) | upper_nz[R]) ?
				seg_encode(bcd_q[4*R +: 4]) : '0;
		end else begin : g_blank
			assign new_patt[gi] = '0;
		end
	end

	assign status.conv_done = (cnt_q == STEP_CNT_W'(VALUE_W - 1));
	assign status.out_stall = valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= (in_value > SAT_LIMIT) ? SAT_LIMIT : in_value;
			bcd_q <= '0;
		end else if (cmd.shift) begin
			val_q <= {val_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], val_q[VALUE_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.shift) begin
			cnt_q <= cnt_q + STEP_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				patt_q[i] <= '0;
			end
		end else if (cmd.write) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				patt_q[i] <= new_patt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.scan) begin
				pos_q   <= (pos_q == POS_W'(DIGIT_COUNT - 1)) ? '0 : pos_q + POS_W'(1);
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			sel_q <= DIGIT_SEL_W'(pos_q);
			seg_q <= patt_q[pos_q];
		end
	end

	assign out_valid = valid_q;
	assign out_sel   = sel_q;
	assign out_seg   = seg_q;

endmodule

@@ sv/seven_segment_decimal_scan_driver_top.sv @@
// top level of the eight-digit multiplexed seven-segment scan driver
//
// requests enter on the s_axis group; s_tuser picks the kind of request:
// 0 loads a new number from s_tdata, 1 is a scan tick. a load gives no
// output; it is converted to decimal digits with leading-zero blanking and
// stored in the digit buffer. values beyond the display range show all nines.
// a load holds the input off from acceptance until it is stored:
// taking the value, 27 shift steps of the binary-to-bcd shifter, one buffer write.
// a scan tick gives one request on the m_axis group in the next cycle with
// the current digit position and its segment pattern (common cathode, bit0
// segment a), then advances the position, wrapping after the last digit.
// scan ticks run at one per cycle while the output is taken and no load is in conversion.
// when the receiver stalls, the output register holds its request and the
// input is not taken until the output request has gone out.
// reset blanks every digit, sets the scan position to the leftmost digit
// and leaves no output request pending.
`include "seven_segment_decimal_scan_driver_top_assert.svh"
module seven_segment_decimal_scan_driver_top #(
	parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ssd_pkg::IN_TDATA_W-1:0]    s_tdata,   // value[26:0], zeros
	input  logic                              s_tuser,   // kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ssd_pkg::OUT_TDATA_W-1:0]   m_tdata    // digit_select[2:0], segments[9:3], zeros
);
	import ssd_pkg::*;

	localparam int PAD_W = OUT_TDATA_W - DIGIT_SEL_W - SEG_W;

	ssd_cmd_t               cmd;
	ssd_status_t            status;
	logic [DIGIT_SEL_W-1:0] out_sel;
	logic [SEG_W-1:0]       out_seg;

	ssd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ssd_dp #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_value  (s_tdata[VALUE_W-1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_sel   (out_sel),
		.out_seg   (out_seg)
	);

	assign m_tdata = {{PAD_W{1'b0}}, out_seg, out_sel};

	`SSD_ASSERT_NEVER(a_no_accept_in_conv, cmd.shift && s_tready, "input taken during conversion")
	`SSD_ASSERT_IMPL(a_load_starts_conv, cmd.load |=> cmd.shift, "load did not start conversion")
	`SSD_ASSERT_IMPL(a_scan_gives_out, cmd.scan |=> m_tvalid, "scan tick gave no output")
	`SSD_ASSERT_NEVER(a_one_cmd, cmd.load && cmd.scan, "load and scan in one cycle")

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the eight-digit seven-segment scan driver
`timescale 1ns / 100ps
module tb_top;
	import ssd_pkg::*;

	localparam int DIGITS = DIGIT_COUNT_DEF;
	localparam longint unsigned SHOWN_MAX = 10**DIGITS - 1;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 850;
	localparam int DIRECTED_ROWS = 26;

	localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;
	localparam logic [SEG_W-1:0] SEG_ZERO = 7'h3F;
	localparam logic [SEG_W-1:0] SEG_NINE = 7'h6F;
	localparam logic [SEG_W-1:0] SEG_LUT [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	typedef struct packed {
		logic [DIGIT_SEL_W-1:0] sel;
		logic [SEG_W-1:0] seg;
	} digit_drive_t;

	typedef struct packed {
		logic kind;
		logic [VALUE_W-1:0] value;
		logic typed;
		digit_drive_t drive;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = KIND_LOAD;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	logic [SEG_W-1:0] digit_buffer [DIGITS];
	logic [DIGIT_SEL_W-1:0] scan_pos;
	digit_drive_t pending_drives [$];
	digit_drive_t want;
	int errors = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;

	stim_row_t directed [DIRECTED_ROWS] = '{
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd0, SEG_BLANK}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd1, SEG_BLANK}},
		'{KIND_LOAD, 27'd0, 1'b0, '{3'd0, SEG_BLANK}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd2, SEG_BLANK}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd3, SEG_BLANK}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd4, SEG_BLANK}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd5, SEG_BLANK}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd6, SEG_BLANK}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd7, SEG_ZERO}},
		'{KIND_LOAD, 27'd99999999, 1'b0, '{3'd0, SEG_BLANK}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd0, SEG_NINE}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd1, SEG_NINE}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd2, SEG_NINE}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd3, SEG_NINE}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd4, SEG_NINE}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd5, SEG_NINE}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd6, SEG_NINE}},
		'{KIND_SCAN, 27'h7FFFFFF, 1'b1, '{3'd7, SEG_NINE}},
		'{KIND_LOAD, 27'h7FFFFFF, 1'b0, '{3'd0, SEG_BLANK}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd0, SEG_NINE}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd1, SEG_NINE}},
		'{KIND_LOAD, 27'd100000000, 1'b0, '{3'd0, SEG_BLANK}},
		'{KIND_SCAN, 27'd0, 1'b1, '{3'd2, SEG_NINE}},
		'{KIND_LOAD, 27'd1234567, 1'b0, '{3'd0, SEG_BLANK}},
		'{KIND_SCAN, 27'd0, 1'b0, '{3'd0, SEG_BLANK}},
		'{KIND_SCAN, 27'd5555, 1'b0, '{3'd0, SEG_BLANK}}
	};

	seven_segment_decimal_scan_driver_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int expected, input int actual);
		$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, expected, actual);
		errors++;
	endtask

	task automatic predict_request(input logic kind, input logic [VALUE_W-1:0] value,
			input logic typed, input digit_drive_t typed_drive);
		longint unsigned v;
		digit_drive_t drive;
		if (kind == KIND_LOAD) begin
			v = 64'(value);
			if (v > SHOWN_MAX) v = SHOWN_MAX;
			for (int i = 0; i < DIGITS; i++) digit_buffer[i] = SEG_BLANK;
			if (v == 64'd0) begin
				digit_buffer[DIGITS-1] = SEG_ZERO;
			end else begin
				for (int i = DIGITS - 1; i >= 0 && v > 64'd0; i--) begin
					digit_buffer[i] = SEG_LUT[int'(v % 64'd10)];
					v = v / 64'd10;
				end
			end
		end else begin
			drive.sel = scan_pos;
			drive.seg = digit_buffer[scan_pos];
			pending_drives.push_back(typed ? typed_drive : drive);
			scan_pos = (scan_pos == DIGIT_SEL_W'(DIGITS - 1)) ? '0 : scan_pos + 1'b1;
		end
	endtask

	task automatic send_request(input logic kind, input logic [VALUE_W-1:0] value,
			input logic typed, input digit_drive_t typed_drive);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {{(IN_TDATA_W-VALUE_W){1'b0}}, value};
		do @(posedge clk); while (!s_tready);
		predict_request(kind, value, typed, typed_drive);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		longint unsigned p;
		p = 64'd10 ** $urandom_range(0, DIGITS);
		case ($urandom_range(0, 5))
			0: return VALUE_W'($urandom_range(0, 99));
			1: return VALUE_W'($urandom());
			2: return VALUE_W'($urandom_range(0, 99999999));
			3: return VALUE_W'(SHOWN_MAX - 64'd1 + 64'($urandom_range(0, 2)));
			4: return VALUE_W'(p - 64'd1 + 64'($urandom_range(0, 1)));
			default: return VALUE_W'($urandom_range(0, 9999));
		endcase
	endfunction

	initial begin
		forever begin
			int w;
			w = quiet ? 0 : $urandom_range(0, 3);
			repeat (w) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_drives.size() == 0) begin
				report_mismatch("unexpected request", 0, int'(m_tdata));
			end else begin
				want = pending_drives.pop_front();
				if (m_tdata[2:0] !== want.sel)
					report_mismatch("digit_select", int'(want.sel), int'(m_tdata[2:0]));
				if (m_tdata[9:3] !== want.seg)
					report_mismatch("segments", int'(want.seg), int'(m_tdata[9:3]));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int run;
		for (int i = 0; i < DIGITS; i++) digit_buffer[i] = SEG_BLANK;
		scan_pos = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_request(directed[r].kind, directed[r].value, directed[r].typed,
				directed[r].drive);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) quiet = ~quiet;
			if ($urandom_range(0, 9) != 0) begin
				send_request(KIND_LOAD, pick_value(), 1'b0, '0);
				sent++;
			end
			run = $urandom_range(0, 12);
			repeat (run) begin
				send_request(KIND_SCAN, VALUE_W'($urandom()), 1'b0, '0);
				sent++;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (pending_drives.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_drives.size() != 0)
			report_mismatch("leftover expectations", 0, pending_drives.size());
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

@@ seven_segment_decimal_scan_driver_top.f @@
+incdir+sv
sv/ssd_pkg.sv
sv/ssd_ctrl.sv
sv/ssd_dp.sv
sv/seven_segment_decimal_scan_driver_top.sv
tb/tb_top.sv
